FILE: hdl/gda_pkg.sv
// Shared widths, codes, calendar tables and divider handshake types.
`timescale 1ns / 1ps

package gda_pkg;

  localparam int REQ_W  = 2;
  localparam int YEAR_W = 14;
  localparam int MON_W  = 4;
  localparam int DAY_W  = 5;
  localparam int CNT_W  = 22;
  localparam int ST_W   = 2;
  localparam int DIV_W  = 22;
  localparam int DVS_W  = 18;

  localparam int MAX_YEAR_DEF = 9999;

  localparam logic [REQ_W-1:0] REQ_ADD   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_SUB   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_DIFF  = 2'd2;
  localparam logic [REQ_W-1:0] REQ_CHECK = 2'd3;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_BAD   = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

  localparam logic [DVS_W-1:0] DAYS_400Y = 18'd146097;
  localparam logic [DVS_W-1:0] DAYS_100Y = 18'd36524;
  localparam logic [DVS_W-1:0] DAYS_4Y   = 18'd1461;
  localparam logic [DVS_W-1:0] DAYS_1Y   = 18'd365;
  localparam logic [DVS_W-1:0] YEARS_C   = 18'd100;
  localparam logic [DVS_W-1:0] YEARS_Q   = 18'd400;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quo;
    logic [DVS_W-1:0] rem;
  } div_rsp_t;

  function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m, input logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // days before the first of month m in a common year
  function automatic logic [8:0] cum_days(input logic [MON_W-1:0] m);
    logic [8:0] c;
    case (m)
      4'd2:    c = 9'd31;
      4'd3:    c = 9'd59;
      4'd4:    c = 9'd90;
      4'd5:    c = 9'd120;
      4'd6:    c = 9'd151;
      4'd7:    c = 9'd181;
      4'd8:    c = 9'd212;
      4'd9:    c = 9'd243;
      4'd10:   c = 9'd273;
      4'd11:   c = 9'd304;
      4'd12:   c = 9'd334;
      default: c = 9'd0;
    endcase
    return c;
  endfunction

  // serial day number of Dec 31 of year y, day 1 being 0001-01-01
  function automatic int last_serial(input int y);
    int p;
    int s;
    p = y - 1;
    s = 365 * p + p / 4 - p / 100 + p / 400 + 365;
    if (((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0) begin
      s = s + 1;
    end
    return s;
  endfunction

endpackage

FILE: hdl/gda_if.sv
// Request and result channel interfaces.
`timescale 1ns / 1ps

interface gda_req_if;
  import gda_pkg::*;
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [YEAR_W-1:0] year;
  logic [MON_W-1:0]  month;
  logic [DAY_W-1:0]  day;
  logic [CNT_W-1:0]  offset_days;
  logic [YEAR_W-1:0] other_year;
  logic [MON_W-1:0]  other_month;
  logic [DAY_W-1:0]  other_day;

  modport source (output valid, req_type, year, month, day, offset_days,
                  other_year, other_month, other_day, input ready);
  modport sink (input valid, req_type, year, month, day, offset_days,
                other_year, other_month, other_day, output ready);
endinterface

interface gda_res_if;
  import gda_pkg::*;
  logic              valid;
  logic              ready;
  logic [YEAR_W-1:0] res_year;
  logic [MON_W-1:0]  res_month;
  logic [DAY_W-1:0]  res_day;
  logic [CNT_W-1:0]  day_difference;
  logic [ST_W-1:0]   status;

  modport source (output valid, res_year, res_month, res_day, day_difference, status,
                  input ready);
  modport sink (input valid, res_year, res_month, res_day, day_difference, status,
                output ready);
endinterface

FILE: hdl/gda_div.sv
// Shared divider by repeated compare and subtract, one step per cycle.
`timescale 1ns / 1ps

module gda_div (
  input  logic               clk,
  input  logic               rst,
  input  gda_pkg::div_req_t  dreq,
  output gda_pkg::div_rsp_t  drsp
);
  import gda_pkg::*;

  logic             busy;
  logic             done;
  logic [DIV_W-1:0] quo;
  logic [DIV_W-1:0] part;
  logic [DVS_W-1:0] dvs;
  logic             fits;

  always_comb begin
    fits = part >= DIV_W'(dvs);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (dreq.start) begin
        busy <= 1'b1;
        quo  <= '0;
        part <= dreq.dividend;
        dvs  <= dreq.divisor;
      end else if (busy) begin
        if (fits) begin
          part <= part - DIV_W'(dvs);
          quo  <= quo + DIV_W'(1);
        end else begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign drsp = '{busy: busy, done: done, quo: quo, rem: part[DVS_W-1:0]};

endmodule

FILE: hdl/gregorian_date_arithmetic.sv
// Gregorian date unit: add, subtract, difference and check of calendar dates.
// Usage:
//   request channel carries req_type and the operand dates / day count; result
//   channel returns one item per request (date, day_difference, status).
//   One request is in flight at a time; request.ready is high only while idle.
//   Each date is turned into a serial day number, 0001-01-01 being day 1, using
//   one shared compare-and-subtract divider under a sequencer; year / 100 (up
//   to 99) dominates. A zero or out-of-range field ends after the field check;
//   a check or a day past month end ends after the day-of-month check; a
//   difference converts both dates; add or subtract take two divides per input
//   date, a range test, four divides to convert back and a month search, and
//   end after the range test when the result falls out of range. The next
//   request is taken only once the sequencer is back in idle.
//   The result sits in an output register; a new request is taken while it
//   waits, and a finished result holds until the previous one is taken.
//   Reset (rst, synchronous) returns the sequencer to idle and drops
//   result.valid; no clearing pass is needed.
`timescale 1ns / 1ps

module gregorian_date_arithmetic #(
  parameter int MAX_YEAR = gda_pkg::MAX_YEAR_DEF
) (
  input logic      clk,
  input logic      rst,
  gda_req_if.sink  request,
  gda_res_if.source result
);
  import gda_pkg::*;

  localparam logic [CNT_W-1:0]  MAXS  = CNT_W'(last_serial(MAX_YEAR));
  localparam logic [YEAR_W-1:0] YMAX  = YEAR_W'(MAX_YEAR);

  typedef enum logic [4:0] {
    S_IDLE, S_CHK, S_P100, S_P400, S_DAY, S_SER1, S_SER2, S_DIFF, S_ADJ,
    S_Q400, S_Q100, S_Q4, S_Q1, S_YEAR, S_MON, S_WAIT, S_OUT
  } state_t;

  state_t state;
  state_t ret;

  logic [REQ_W-1:0]  req;
  logic [YEAR_W-1:0] ya;
  logic [MON_W-1:0]  ma;
  logic [DAY_W-1:0]  da;
  logic [YEAR_W-1:0] yb;
  logic [MON_W-1:0]  mb;
  logic [DAY_W-1:0]  db;
  logic [CNT_W-1:0]  off;
  logic              sel_b;
  logic [6:0]        pq100;
  logic [6:0]        pr100;
  logic [4:0]        pq400;
  logic              leap;
  logic [CNT_W-1:0]  acc;
  logic [CNT_W-1:0]  sa;
  logic [4:0]        sq400;
  logic [1:0]        sq100;
  logic [4:0]        sq4;
  logic [MON_W-1:0]  mo;

  logic [YEAR_W-1:0] ry;
  logic [MON_W-1:0]  rm;
  logic [DAY_W-1:0]  rd;
  logic [CNT_W-1:0]  rdiff;
  logic [ST_W-1:0]   rstat;

  logic              ov;
  logic [YEAR_W-1:0] oy;
  logic [MON_W-1:0]  om;
  logic [DAY_W-1:0]  od;
  logic [CNT_W-1:0]  odiff;
  logic [ST_W-1:0]   ostat;

  logic [YEAR_W-1:0] ysel;
  logic [MON_W-1:0]  msel;
  logic [DAY_W-1:0]  dsel;
  logic [YEAR_W-1:0] p;
  logic              range_ok;
  logic              leap_now;
  logic [DAY_W-1:0]  dlen;
  logic [DVS_W-1:0]  r100y;
  logic [1:0]        q1c;
  logic [DVS_W-1:0]  r1y;
  logic [DAY_W-1:0]  mlen;
  logic              out_load;

  div_req_t dreq;
  div_rsp_t drsp;

  gda_div u_div (
    .clk  (clk),
    .rst  (rst),
    .dreq (dreq),
    .drsp (drsp)
  );

  always_comb begin
    ysel     = sel_b ? yb : ya;
    msel     = sel_b ? mb : ma;
    dsel     = sel_b ? db : da;
    p        = ysel - YEAR_W'(1);
    range_ok = (ysel != '0) && (ysel <= YMAX) && (msel != '0) && (msel <= 4'd12)
               && (dsel != '0);
    leap_now = (ysel[1:0] == 2'b00) && ((pr100 != 7'd99) || (drsp.rem == DVS_W'(399)));
    dlen     = month_len(msel, leap_now);
    r100y    = (drsp.quo > DIV_W'(3)) ? DVS_W'(drsp.rem + DAYS_100Y) : drsp.rem;
    q1c      = (drsp.quo > DIV_W'(3)) ? 2'd3 : drsp.quo[1:0];
    r1y      = (drsp.quo > DIV_W'(3)) ? DVS_W'(drsp.rem + DAYS_1Y) : drsp.rem;
    mlen     = month_len(mo, leap);
    out_load = (state == S_OUT) && (!ov || result.ready);
  end

  always_comb begin
    dreq.start    = 1'b0;
    dreq.dividend = '0;
    dreq.divisor  = '0;
    unique case (state)
      S_P100: begin
        dreq.start    = 1'b1;
        dreq.dividend = DIV_W'(p);
        dreq.divisor  = YEARS_C;
      end
      S_P400: begin
        dreq.start    = 1'b1;
        dreq.dividend = DIV_W'(p);
        dreq.divisor  = YEARS_Q;
      end
      S_Q400: begin
        dreq.start    = 1'b1;
        dreq.dividend = acc;
        dreq.divisor  = DAYS_400Y;
      end
      S_Q100: begin
        dreq.start    = 1'b1;
        dreq.dividend = DIV_W'(drsp.rem);
        dreq.divisor  = DAYS_100Y;
      end
      S_Q4: begin
        dreq.start    = 1'b1;
        dreq.dividend = DIV_W'(r100y);
        dreq.divisor  = DAYS_4Y;
      end
      S_Q1: begin
        dreq.start    = 1'b1;
        dreq.dividend = DIV_W'(drsp.rem);
        dreq.divisor  = DAYS_1Y;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret   <= S_IDLE;
      ov    <= 1'b0;
    end else begin
      if (out_load) begin
        ov <= 1'b1;
      end else if (result.ready) begin
        ov <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (request.valid) begin
            req   <= request.req_type;
            ya    <= request.year;
            ma    <= request.month;
            da    <= request.day;
            off   <= request.offset_days;
            yb    <= request.other_year;
            mb    <= request.other_month;
            db    <= request.other_day;
            sel_b <= 1'b0;
            ry    <= '0;
            rm    <= '0;
            rd    <= '0;
            rdiff <= '0;
            rstat <= ST_OK;
            state <= S_CHK;
          end
        end
        S_CHK: begin
          if (!range_ok) begin
            rstat <= ST_BAD;
            state <= S_OUT;
          end else begin
            state <= S_P100;
          end
        end
        S_P100: begin
          ret   <= S_P400;
          state <= S_WAIT;
        end
        S_P400: begin
          pq100 <= drsp.quo[6:0];
          pr100 <= drsp.rem[6:0];
          ret   <= S_DAY;
          state <= S_WAIT;
        end
        S_DAY: begin
          pq400 <= drsp.quo[4:0];
          leap  <= leap_now;
          if (dsel > dlen) begin
            rstat <= ST_BAD;
            state <= S_OUT;
          end else if (req == REQ_CHECK) begin
            ry    <= ya;
            rm    <= ma;
            rd    <= da;
            state <= S_OUT;
          end else begin
            state <= S_SER1;
          end
        end
        S_SER1: begin
          acc   <= CNT_W'(p) * CNT_W'(365) + CNT_W'(p[YEAR_W-1:2]) - CNT_W'(pq100);
          state <= S_SER2;
        end
        S_SER2: begin
          acc <= acc + CNT_W'(pq400) + CNT_W'(cum_days(msel))
                 + CNT_W'(leap && (msel > 4'd2)) + CNT_W'(dsel);
          if (sel_b) begin
            state <= S_DIFF;
          end else if (req == REQ_DIFF) begin
            sel_b <= 1'b1;
            state <= S_CHK;
          end else begin
            state <= S_ADJ;
          end
          if (!sel_b) begin
            sa <= acc + CNT_W'(pq400) + CNT_W'(cum_days(msel))
                  + CNT_W'(leap && (msel > 4'd2)) + CNT_W'(dsel);
          end
        end
        S_DIFF: begin
          rdiff <= (sa > acc) ? sa - acc : acc - sa;
          state <= S_OUT;
        end
        S_ADJ: begin
          if (req == REQ_ADD) begin
            if (off > MAXS - sa) begin
              rstat <= ST_RANGE;
              state <= S_OUT;
            end else begin
              acc   <= sa + off - CNT_W'(1);
              state <= S_Q400;
            end
          end else begin
            if (off >= sa) begin
              rstat <= ST_RANGE;
              state <= S_OUT;
            end else begin
              acc   <= sa - off - CNT_W'(1);
              state <= S_Q400;
            end
          end
        end
        S_Q400: begin
          ret   <= S_Q100;
          state <= S_WAIT;
        end
        S_Q100: begin
          sq400 <= drsp.quo[4:0];
          ret   <= S_Q4;
          state <= S_WAIT;
        end
        S_Q4: begin
          sq100 <= (drsp.quo > DIV_W'(3)) ? 2'd3 : drsp.quo[1:0];
          ret   <= S_Q1;
          state <= S_WAIT;
        end
        S_Q1: begin
          sq4   <= drsp.quo[4:0];
          ret   <= S_YEAR;
          state <= S_WAIT;
        end
        S_YEAR: begin
          ry    <= YEAR_W'(sq400) * YEAR_W'(400) + YEAR_W'(sq100) * YEAR_W'(100)
                   + YEAR_W'({sq4, 2'b00}) + YEAR_W'(q1c) + YEAR_W'(1);
          leap  <= (q1c == 2'd3) && ((sq4 != 5'd24) || (sq100 == 2'd3));
          acc   <= CNT_W'(r1y);
          mo    <= 4'd1;
          state <= S_MON;
        end
        S_MON: begin
          if ((acc >= CNT_W'(mlen)) && (mo < 4'd12)) begin
            acc <= acc - CNT_W'(mlen);
            mo  <= mo + 4'd1;
          end else begin
            rm    <= mo;
            rd    <= DAY_W'(acc) + DAY_W'(1);
            state <= S_OUT;
          end
        end
        S_WAIT: begin
          if (drsp.done) begin
            state <= ret;
          end
        end
        S_OUT: begin
          if (out_load) begin
            oy    <= ry;
            om    <= rm;
            od    <= rd;
            odiff <= rdiff;
            ostat <= rstat;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign request.ready         = (state == S_IDLE);
  assign result.valid          = ov;
  assign result.res_year       = oy;
  assign result.res_month      = om;
  assign result.res_day        = od;
  assign result.day_difference = odiff;
  assign result.status         = ostat;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    request.valid && request.ready |=> !request.ready)
    else $error("request taken while an item is in progress");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && (result.status != ST_OK) |->
      (result.res_year == '0) && (result.res_month == '0) && (result.res_day == '0)
      && (result.day_difference == '0))
    else $error("error result carries nonzero fields");

  a_date_whole: assert property (@(posedge clk) disable iff (rst)
    result.valid && (result.status == ST_OK) && (result.res_month != '0) |->
      (result.res_day != '0) && (result.res_year != '0) && (result.res_month <= 4'd12))
    else $error("partial result date");

  a_div_idle_start: assert property (@(posedge clk) disable iff (rst)
    dreq.start |-> !drsp.busy)
    else $error("divider restarted while busy");
`endif

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for gregorian_date_arithmetic: directed and random date requests.
`timescale 1ns / 1ps

typedef struct packed {
  logic [gda_pkg::REQ_W-1:0]  req_type;
  logic [gda_pkg::YEAR_W-1:0] year;
  logic [gda_pkg::MON_W-1:0]  month;
  logic [gda_pkg::DAY_W-1:0]  day;
  logic [gda_pkg::CNT_W-1:0]  offset_days;
  logic [gda_pkg::YEAR_W-1:0] other_year;
  logic [gda_pkg::MON_W-1:0]  other_month;
  logic [gda_pkg::DAY_W-1:0]  other_day;
} date_req_t;

typedef struct packed {
  logic [gda_pkg::YEAR_W-1:0] res_year;
  logic [gda_pkg::MON_W-1:0]  res_month;
  logic [gda_pkg::DAY_W-1:0]  res_day;
  logic [gda_pkg::CNT_W-1:0]  day_difference;
  logic [gda_pkg::ST_W-1:0]   status;
} date_res_t;

class date_scoreboard;
  date_res_t   expected_q[$];
  int unsigned mismatches;

  function new();
    mismatches = 0;
  endfunction

  function bit is_leap(int unsigned y);
    return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
  endfunction

  function int unsigned month_days(int unsigned m, int unsigned y);
    int unsigned len;
    case (m)
      1, 3, 5, 7, 8, 10, 12: len = 31;
      4, 6, 9, 11:           len = 30;
      2:                     len = is_leap(y) ? 29 : 28;
      default:               len = 0;
    endcase
    return len;
  endfunction

  function bit date_valid(int unsigned y, int unsigned m, int unsigned d);
    return y >= 1 && y <= gda_pkg::MAX_YEAR_DEF && m >= 1 && m <= 12 &&
           d >= 1 && d <= month_days(m, y);
  endfunction

  // 0001-01-01 is day 1
  function int unsigned day_number(int unsigned y, int unsigned m, int unsigned d);
    int unsigned p;
    int unsigned s;
    p = y - 1;
    s = 365 * p + p / 4 - p / 100 + p / 400;
    for (int unsigned i = 1; i < m; i++) s += month_days(i, y);
    return s + d;
  endfunction

  function void date_of_day(int unsigned s, output int unsigned y, output int unsigned m,
                            output int unsigned d);
    int unsigned n, q400, q100, q4, q1, r, len;
    n = s - 1;
    q400 = n / 146097;
    r = n % 146097;
    q100 = r / 36524;
    if (q100 > 3) q100 = 3;
    r -= q100 * 36524;
    q4 = r / 1461;
    r = r % 1461;
    q1 = r / 365;
    if (q1 > 3) q1 = 3;
    r -= q1 * 365;
    y = 400 * q400 + 100 * q100 + 4 * q4 + q1 + 1;
    m = 1;
    len = month_days(m, y);
    while (r >= len && m < 12) begin
      r -= len;
      m++;
      len = month_days(m, y);
    end
    d = r + 1;
  endfunction

  function date_res_t predict_result(date_req_t r);
    date_res_t   e;
    int unsigned s, a, b, last, yy, mm, dd;
    e = '0;
    last = day_number(gda_pkg::MAX_YEAR_DEF, 12, 31);
    if (!date_valid(r.year, r.month, r.day) ||
        (r.req_type == gda_pkg::REQ_DIFF &&
         !date_valid(r.other_year, r.other_month, r.other_day))) begin
      e.status = gda_pkg::ST_BAD;
    end else begin
      case (r.req_type)
        gda_pkg::REQ_ADD, gda_pkg::REQ_SUB: begin
          s = day_number(r.year, r.month, r.day);
          if ((r.req_type == gda_pkg::REQ_ADD && r.offset_days > last - s) ||
              (r.req_type == gda_pkg::REQ_SUB && r.offset_days >= s)) begin
            e.status = gda_pkg::ST_RANGE;
          end else begin
            s = (r.req_type == gda_pkg::REQ_ADD) ? s + r.offset_days : s - r.offset_days;
            date_of_day(s, yy, mm, dd);
            e.res_year  = yy[gda_pkg::YEAR_W-1:0];
            e.res_month = mm[gda_pkg::MON_W-1:0];
            e.res_day   = dd[gda_pkg::DAY_W-1:0];
          end
        end
        gda_pkg::REQ_DIFF: begin
          a = day_number(r.year, r.month, r.day);
          b = day_number(r.other_year, r.other_month, r.other_day);
          s = (a > b) ? a - b : b - a;
          e.day_difference = s[gda_pkg::CNT_W-1:0];
        end
        default: begin
          e.res_year  = r.year;
          e.res_month = r.month;
          e.res_day   = r.day;
        end
      endcase
    end
    return e;
  endfunction

  function void note_request(date_req_t r);
    expected_q.push_back(predict_result(r));
  endfunction

  function void check_result(date_res_t got);
    date_res_t e;
    if (expected_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result: %0d-%0d-%0d diff %0d status %0d",
                 got.res_year, got.res_month, got.res_day, got.day_difference, got.status);
      return;
    end
    e = expected_q.pop_front();
    if (got.res_year !== e.res_year || got.res_month !== e.res_month ||
        got.res_day !== e.res_day || got.day_difference !== e.day_difference ||
        got.status !== e.status) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: exp %0d-%0d-%0d diff %0d st %0d, got %0d-%0d-%0d diff %0d st %0d",
                 e.res_year, e.res_month, e.res_day, e.day_difference, e.status,
                 got.res_year, got.res_month, got.res_day, got.day_difference, got.status);
    end
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  function bit failed();
    return mismatches != 0 || expected_q.size() != 0;
  endfunction
endclass

module tb_top;
  import gda_pkg::*;

  localparam int LIMIT_CYCLES = 2000000;
  localparam int HOLD_CYCLES  = 2000;

  logic clk;
  logic rst = 1'b1;
  logic rcv_ready = 1'b0;
  int   stall_pct = 0;
  int   results_seen = 0;
  int   hold_left = 0;
  bit   hold_done = 1'b0;
  int   cycles = 0;

  date_scoreboard sb;

  gda_req_if req_if ();
  gda_res_if res_if ();

  assign res_if.ready = rcv_ready;

  gregorian_date_arithmetic dut (
    .clk     (clk),
    .rst     (rst),
    .request (req_if),
    .result  (res_if)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // result side: random stalls plus one long hold-off to back up the input
  always @(posedge clk) begin
    if (rst) begin
      rcv_ready <= 1'b0;
    end else begin
      if (res_if.valid && rcv_ready) begin
        sb.check_result('{res_if.res_year, res_if.res_month, res_if.res_day,
                          res_if.day_difference, res_if.status});
        results_seen <= results_seen + 1;
      end
      if (!hold_done && results_seen == 100) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
        rcv_ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        rcv_ready <= 1'b0;
      end else begin
        rcv_ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
      end
    end
  end

  function automatic date_req_t mk(logic [REQ_W-1:0] k, int y, int m, int d, int off,
                                   int oy, int om, int od);
    date_req_t r;
    r.req_type    = k;
    r.year        = y[YEAR_W-1:0];
    r.month       = m[MON_W-1:0];
    r.day         = d[DAY_W-1:0];
    r.offset_days = off[CNT_W-1:0];
    r.other_year  = oy[YEAR_W-1:0];
    r.other_month = om[MON_W-1:0];
    r.other_day   = od[DAY_W-1:0];
    return r;
  endfunction

  function automatic void random_date(output logic [YEAR_W-1:0] y,
                                      output logic [MON_W-1:0] m,
                                      output logic [DAY_W-1:0] d);
    int unsigned pick, yy, mm, len;
    pick = $urandom_range(99);
    if (pick < 60) yy = $urandom_range(1, MAX_YEAR_DEF);
    else if (pick < 72) yy = $urandom_range(1, 6);
    else if (pick < 84) yy = $urandom_range(MAX_YEAR_DEF - 5, MAX_YEAR_DEF);
    else yy = 100 * $urandom_range(1, MAX_YEAR_DEF / 100);
    mm = $urandom_range(1, 12);
    len = sb.month_days(mm, yy);
    y = yy[YEAR_W-1:0];
    m = mm[MON_W-1:0];
    d = ($urandom_range(4) == 0) ? len[DAY_W-1:0] : DAY_W'($urandom_range(1, len));
  endfunction

  function automatic date_req_t random_request();
    date_req_t   r;
    int unsigned pick;
    if ($urandom_range(99) < 12) begin
      r.req_type    = REQ_W'($urandom);
      r.year        = YEAR_W'($urandom);
      r.month       = MON_W'($urandom);
      r.day         = DAY_W'($urandom);
      r.offset_days = CNT_W'($urandom);
      r.other_year  = YEAR_W'($urandom);
      r.other_month = MON_W'($urandom);
      r.other_day   = DAY_W'($urandom);
      return r;
    end
    pick = $urandom_range(9);
    r.req_type = (pick < 3) ? REQ_ADD : (pick < 6) ? REQ_SUB : (pick < 9) ? REQ_DIFF : REQ_CHECK;
    random_date(r.year, r.month, r.day);
    random_date(r.other_year, r.other_month, r.other_day);
    case ($urandom_range(3))
      0:       r.offset_days = CNT_W'($urandom_range(0, 400));
      1:       r.offset_days = CNT_W'($urandom_range(0, 40000));
      2:       r.offset_days = CNT_W'($urandom_range(0, 3652058));
      default: r.offset_days = CNT_W'($urandom);
    endcase
    return r;
  endfunction

  task automatic send_request(input date_req_t r, input int gap_pct);
    while ($urandom_range(99) < gap_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid       <= 1'b1;
    req_if.req_type    <= r.req_type;
    req_if.year        <= r.year;
    req_if.month       <= r.month;
    req_if.day         <= r.day;
    req_if.offset_days <= r.offset_days;
    req_if.other_year  <= r.other_year;
    req_if.other_month <= r.other_month;
    req_if.other_day   <= r.other_day;
    do @(posedge clk); while (req_if.ready !== 1'b1);
    sb.note_request(r);
  endtask

  initial begin
    int gap;
    sb = new();
    req_if.valid       <= 1'b0;
    req_if.req_type    <= '0;
    req_if.year        <= '0;
    req_if.month       <= '0;
    req_if.day         <= '0;
    req_if.offset_days <= '0;
    req_if.other_year  <= '0;
    req_if.other_month <= '0;
    req_if.other_day   <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // field extremes, bad dates, range edges, leap rules
    send_request(mk(REQ_CHECK, 1, 1, 1, 0, 0, 0, 0), 0);
    send_request(mk(REQ_CHECK, 9999, 12, 31, 0, 0, 0, 0), 0);
    send_request(mk(REQ_CHECK, 0, 1, 1, 0, 0, 0, 0), 0);
    send_request(mk(REQ_CHECK, 10000, 1, 1, 0, 0, 0, 0), 0);
    send_request(mk(REQ_CHECK, 16383, 15, 31, 4194303, 16383, 15, 31), 0);
    send_request(mk(REQ_ADD, 2001, 0, 1, 10, 0, 0, 0), 0);
    send_request(mk(REQ_SUB, 2001, 13, 1, 10, 0, 0, 0), 0);
    send_request(mk(REQ_CHECK, 2001, 4, 31, 0, 0, 0, 0), 0);
    send_request(mk(REQ_CHECK, 2001, 4, 0, 0, 0, 0, 0), 0);
    send_request(mk(REQ_CHECK, 1900, 2, 29, 0, 0, 0, 0), 0);
    send_request(mk(REQ_CHECK, 2000, 2, 29, 0, 0, 0, 0), 0);
    send_request(mk(REQ_ADD, 2004, 2, 29, 365, 0, 0, 0), 0);
    send_request(mk(REQ_ADD, 1, 1, 1, 0, 0, 0, 0), 0);
    send_request(mk(REQ_ADD, 1, 1, 1, 3652058, 0, 0, 0), 0);
    send_request(mk(REQ_ADD, 1, 1, 1, 3652059, 0, 0, 0), 0);
    send_request(mk(REQ_ADD, 9999, 12, 31, 1, 0, 0, 0), 0);
    send_request(mk(REQ_ADD, 5000, 6, 15, 4194303, 16383, 15, 31), 0);
    send_request(mk(REQ_SUB, 1, 1, 1, 1, 0, 0, 0), 0);
    send_request(mk(REQ_SUB, 1, 1, 1, 0, 0, 0, 0), 0);
    send_request(mk(REQ_SUB, 9999, 12, 31, 3652058, 0, 0, 0), 0);
    send_request(mk(REQ_SUB, 2000, 3, 1, 1, 0, 0, 0), 0);
    send_request(mk(REQ_DIFF, 1, 1, 1, 0, 9999, 12, 31), 0);
    send_request(mk(REQ_DIFF, 9999, 12, 31, 4194303, 1, 1, 1), 0);
    send_request(mk(REQ_DIFF, 2024, 7, 4, 0, 2024, 7, 4), 0);
    send_request(mk(REQ_DIFF, 2024, 7, 4, 0, 2023, 2, 29), 0);
    send_request(mk(REQ_DIFF, 1, 1, 0, 0, 1, 1, 1), 0);

    for (int ph = 0; ph < 4; ph++) begin
      stall_pct <= (ph == 2) ? 63 : (ph == 3) ? 26 : 0;
      gap = (ph == 1) ? 63 : (ph == 3) ? 26 : 0;
      repeat (250) send_request(random_request(), gap);
    end
    req_if.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.failed()) begin
      $display("tb_top: done, errors");
    end else begin
      $display("tb_top: done, clean");
    end
    $finish;
  end
endmodule

FILE: files.f
hdl/gda_pkg.sv
hdl/gda_if.sv
hdl/gda_div.sv
hdl/gregorian_date_arithmetic.sv
verif/tb_top.sv
